/* design/mot_pkg.sv */
// Shared types and constants of the multi-object tracker association core.
// No dependencies; every other design file but mot_fifo imports this package.
`default_nettype none

package mot_pkg;

  // Default sizes, handed to the top-level parameters
  localparam int MAX_TRACKS_DEF     = 16;
  localparam int MAX_DETECTIONS_DEF = 16;
  localparam int COORD_BITS_DEF     = 20;

  // Fixed field widths
  localparam int DIST_BITS  = 16;
  localparam int COST_BITS  = 17;
  localparam int POT_BITS   = 32;
  localparam int SQ_BITS    = 34;
  localparam int STAMP_BITS = 32;
  localparam int ID_BITS    = 16;
  localparam int MISS_BITS  = 8;
  localparam int REG_BITS   = 32;

  // Gated pair costs this margin more than the gate
  localparam int GATE_MARGIN = 256;
  // Top even bit position of the square-root unit
  localparam int SQRT_TOP    = 32;
  // Depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 4;

  localparam logic signed [POT_BITS-1:0] BIG_COST = 32'sh4000_0000;
  localparam logic [MISS_BITS-1:0]       MISS_SAT = 8'hFF;

  // Register indexes of the configuration port
  localparam logic [1:0] REG_MAX_DISTANCE   = 2'd0;
  localparam logic [1:0] REG_MAX_MISSED     = 2'd1;
  localparam logic [1:0] REG_ALERT_DURATION = 2'd2;
  localparam logic [1:0] REG_LOST_TIMEOUT   = 2'd3;

  typedef struct packed {
    logic [DIST_BITS-1:0]  max_distance;
    logic [MISS_BITS-1:0]  max_missed;
    logic [STAMP_BITS-1:0] alert_duration_ms;
    logic [STAMP_BITS-1:0] lost_timeout_ms;
  } mot_cfg_t;

  // Classification of one queued command
  typedef struct packed {
    logic store;  // detection goes into the buffer
    logic drop;   // detection lost, buffer full
    logic last;   // frame end, start processing
  } mot_flags_t;

  localparam int FLAG_BITS = 3;

  typedef enum logic [4:0] {
    B_IDLE, B_DIFF, B_GATE, B_SQ, B_CMP, B_SQRT,
    B_SINIT, B_ROW, B_ITER, B_ADDR, B_CALC, B_UPD, B_CHK, B_AUG, B_RC,
    B_TADDR, B_TCALC, B_PACK, B_SPAWN, B_PREP, B_EMIT
  } mot_state_t;

endpackage

`default_nettype wire

/* design/mot_channels.sv */
// Valid/ready channel interfaces: detection input and track result output.
// Depends on mot_pkg for default widths.
`default_nettype none

interface mot_det_if import mot_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic signed [COORD_BITS-1:0] pos_z;
  logic [STAMP_BITS-1:0]        stamp_ms;
  logic                         has_detection;
  logic                         frame_end;

  modport source (output valid, pos_x, pos_y, pos_z, stamp_ms, has_detection, frame_end,
                  input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, stamp_ms, has_detection, frame_end,
                output ready);
endinterface

interface mot_trk_if import mot_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic [ID_BITS-1:0]           track_id;
  logic signed [COORD_BITS-1:0] track_x;
  logic signed [COORD_BITS-1:0] track_y;
  logic signed [COORD_BITS-1:0] track_z;
  logic [MISS_BITS-1:0]         missed_count;
  logic                         alert_now;
  logic                         still_valid;
  logic                         table_empty;
  logic                         dropped;
  logic                         last_result;

  modport source (output valid, track_id, track_x, track_y, track_z, missed_count,
                  alert_now, still_valid, table_empty, dropped, last_result,
                  input ready);
  modport sink (input valid, track_id, track_x, track_y, track_z, missed_count,
                alert_now, still_valid, table_empty, dropped, last_result,
                output ready);
endinterface

`default_nettype wire

/* design/mot_fifo.sv */
// Small register queue between the front and the back of the tracker.
// Depends on nothing but its parameters.
`default_nettype none

module mot_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             full,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    fill;

  assign full  = (fill == NW'(DEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        slots[wr_ptr] <= push_data;
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + NW'(push && !full) - NW'(pop && !empty);
    end
  end
endmodule

`default_nettype wire

/* design/mot_front.sv */
// Front end: accepts input items, counts detections per frame and classifies
// each item into a queue command. Depends on mot_pkg and mot_channels.
`default_nettype none

module mot_front import mot_pkg::*; #(
  parameter int MAX_DETECTIONS = MAX_DETECTIONS_DEF,
  parameter int COORD_BITS     = COORD_BITS_DEF,
  parameter int CMD_BITS       = FLAG_BITS + 3 * COORD_BITS + STAMP_BITS
) (
  input  logic                clk,
  input  logic                rst,
  mot_det_if.sink             det,
  output logic                push,
  output logic [CMD_BITS-1:0] push_data,
  input  logic                full
);
  localparam int DCW = $clog2(MAX_DETECTIONS + 1);

  logic [DCW-1:0] det_count;
  logic           transfer;
  logic           room;
  mot_flags_t     flags;

  assign det.ready = !full;
  assign transfer  = det.valid && det.ready;
  assign room      = (det_count < DCW'(MAX_DETECTIONS));

  // Classify the item
  always_comb begin
    flags.store = det.has_detection && room;
    flags.drop  = det.has_detection && !room;
    flags.last  = det.frame_end;
  end

  // Items that neither carry a detection nor end a frame change nothing
  assign push      = transfer && (det.has_detection || det.frame_end);
  assign push_data = {flags, det.pos_x, det.pos_y, det.pos_z, det.stamp_ms};

  // Track buffer occupancy of the current frame
  always_ff @(posedge clk) begin
    if (rst) begin
      det_count <= '0;
    end else if (transfer) begin
      if (det.frame_end) begin
        det_count <= '0;
      end else if (flags.store) begin
        det_count <= det_count + 1'b1;
      end
    end
  end
endmodule

`default_nettype wire

/* design/mot_back.sv */
// Back end: cost matrix, Hungarian solve, track update, compaction, spawn and
// emission of the track table. Depends on mot_pkg and mot_channels.
`default_nettype none

module mot_back import mot_pkg::*; #(
  parameter int MAX_TRACKS     = MAX_TRACKS_DEF,
  parameter int MAX_DETECTIONS = MAX_DETECTIONS_DEF,
  parameter int COORD_BITS     = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mot_cfg_t                     cfg,
  input  logic                         cmd_valid,
  output logic                         cmd_pop,
  input  mot_flags_t                   cmd_flags,
  input  logic signed [COORD_BITS-1:0] cmd_x,
  input  logic signed [COORD_BITS-1:0] cmd_y,
  input  logic signed [COORD_BITS-1:0] cmd_z,
  input  logic [STAMP_BITS-1:0]        cmd_stamp,
  mot_trk_if.source                    trk
);
  localparam int DIM  = (MAX_TRACKS > MAX_DETECTIONS) ? MAX_TRACKS : MAX_DETECTIONS;
  localparam int CW   = $clog2(DIM + 2);
  localparam int IW   = $clog2(DIM + 1);
  localparam int DW   = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int TIW  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int DIW  = (MAX_DETECTIONS > 1) ? $clog2(MAX_DETECTIONS) : 1;
  localparam int DIFW = COORD_BITS + 1;
  localparam int CMD_DEPTH = 2 ** (2 * DW);

  function automatic logic [DIFW-1:0] abs_diff(input logic signed [COORD_BITS-1:0] a,
                                                input logic signed [COORD_BITS-1:0] b);
    logic signed [DIFW-1:0] d;
    d = DIFW'(a) - DIFW'(b);
    return d[DIFW-1] ? DIFW'(-d) : DIFW'(d);
  endfunction

  mot_state_t state, state_next;

  // Counters and table sizes
  logic [CW-1:0] i_cnt, j_cnt, w_cnt, n_cnt, m_cnt, k_cnt;
  logic [ID_BITS-1:0] id_ctr;
  logic drop_flag, frame_drop;
  logic [STAMP_BITS-1:0] stamp;
  logic alert_hit;
  logic [TIW-1:0] alert_idx;

  // Track table
  logic signed [COORD_BITS-1:0] t_x [MAX_TRACKS];
  logic signed [COORD_BITS-1:0] t_y [MAX_TRACKS];
  logic signed [COORD_BITS-1:0] t_z [MAX_TRACKS];
  logic [ID_BITS-1:0]    t_id [MAX_TRACKS];
  logic [STAMP_BITS-1:0] t_seen [MAX_TRACKS];
  logic [STAMP_BITS-1:0] t_first [MAX_TRACKS];
  logic [MISS_BITS-1:0]  t_miss [MAX_TRACKS];
  logic [MAX_TRACKS-1:0] t_fset, t_valid, t_alert;

  // Detection buffer
  logic signed [COORD_BITS-1:0] d_x [MAX_DETECTIONS];
  logic signed [COORD_BITS-1:0] d_y [MAX_DETECTIONS];
  logic signed [COORD_BITS-1:0] d_z [MAX_DETECTIONS];
  logic [MAX_DETECTIONS-1:0] matched;

  // Cost memory
  logic [COST_BITS-1:0] cost_mem [CMD_DEPTH];
  logic [COST_BITS-1:0] cost_rd, cost_wdata;
  logic [2*DW-1:0] cost_raddr, cost_waddr;
  logic cost_we;

  // Distance unit
  logic [DIFW-1:0] dif [3];
  logic [1:0] sq_idx;
  logic [SQ_BITS-1:0] acc, rem, root, bitv;

  // Solver state
  logic signed [POT_BITS-1:0] u_pot [DIM+1];
  logic signed [POT_BITS-1:0] v_pot [DIM+1];
  logic signed [POT_BITS-1:0] minv [DIM+1];
  logic [IW-1:0] p_arr [DIM+1];
  logic [IW-1:0] way [DIM+1];
  logic [DIM:0] used;
  logic signed [POT_BITS-1:0] delta;
  logic [IW-1:0] j0, j1, i0;
  logic [DW-1:0] rc [DIM];
  logic [DIM-1:0] rc_ok;

  // Output register
  logic ovalid;
  logic [ID_BITS-1:0] o_id;
  logic signed [COORD_BITS-1:0] o_x, o_y, o_z;
  logic [MISS_BITS-1:0] o_miss;
  logic o_alert, o_valid, o_empty, o_drop, o_last;

  // Shared combinational terms
  logic [CW-1:0] m_new, k_new;
  logic [COST_BITS-1:0] gated;
  logic far, sq_over, take, pair_last, j_at_k, load, emit_last;
  logic [DIST_BITS-1:0] sq_in;
  logic [2*DIST_BITS-1:0] sq_prod, md_sq;
  logic [SQ_BITS-1:0] trial, root_step;
  logic [IW-1:0] jx, i0m, jm;
  logic [TIW-1:0] ti;
  logic [DW-1:0] ri;
  logic [DIW-1:0] dj;
  logic pad, match_ok, alert_fire;
  logic signed [POT_BITS-1:0] cur, nmin;
  logic [STAMP_BITS-1:0] first_eff;
  logic [MISS_BITS-1:0] miss_new;

  assign m_new = m_cnt + CW'(cmd_flags.store);
  assign k_new = (n_cnt > m_cnt) ? n_cnt : m_cnt;
  assign gated = COST_BITS'(cfg.max_distance) + COST_BITS'(GATE_MARGIN);
  assign far = (SQ_BITS'(dif[0]) > SQ_BITS'(cfg.max_distance)) ||
               (SQ_BITS'(dif[1]) > SQ_BITS'(cfg.max_distance)) ||
               (SQ_BITS'(dif[2]) > SQ_BITS'(cfg.max_distance));
  assign sq_in   = DIST_BITS'(dif[sq_idx]);
  assign sq_prod = sq_in * sq_in;
  assign md_sq   = cfg.max_distance * cfg.max_distance;
  assign sq_over = acc > SQ_BITS'(md_sq);
  assign trial   = root + bitv;
  assign take    = rem >= trial;
  assign root_step = take ? ((root >> 1) + bitv) : (root >> 1);
  assign pair_last = (j_cnt == m_cnt - 1'b1) && (i_cnt == n_cnt - 1'b1);
  assign jx     = j_cnt[IW-1:0];
  assign j_at_k = (j_cnt == k_cnt);
  assign i0m    = i0 - 1'b1;
  assign jm     = jx - 1'b1;
  assign ti     = i_cnt[TIW-1:0];
  assign ri     = i_cnt[DW-1:0];
  assign dj     = DIW'(rc[ri]);
  assign load   = (state == B_EMIT) && (!ovalid || trk.ready);
  assign emit_last = (n_cnt == '0) || (i_cnt == n_cnt - 1'b1);

  // Reduced cost of the scanned column; padded rows and columns cost zero
  assign pad  = (CW'(i0) > n_cnt) || (j_cnt > m_cnt);
  assign cur  = (pad ? '0 : POT_BITS'(cost_rd)) - u_pot[i0] - v_pot[jx];
  assign nmin = (cur < minv[jx]) ? cur : minv[jx];

  // Track update decisions
  assign match_ok  = rc_ok[ri] && (CW'(rc[ri]) < m_cnt) &&
                     (cost_rd <= COST_BITS'(cfg.max_distance));
  assign first_eff = t_fset[ti] ? t_first[ti] : stamp;
  assign alert_fire = (stamp >= first_eff) &&
                      (stamp - first_eff >= cfg.alert_duration_ms) && !t_alert[ti];
  assign miss_new = (t_miss[ti] == MISS_SAT) ? t_miss[ti] : t_miss[ti] + 1'b1;

  assign trk.valid        = ovalid;
  assign trk.track_id     = o_id;
  assign trk.track_x      = o_x;
  assign trk.track_y      = o_y;
  assign trk.track_z      = o_z;
  assign trk.missed_count = o_miss;
  assign trk.alert_now    = o_alert;
  assign trk.still_valid  = o_valid;
  assign trk.table_empty  = o_empty;
  assign trk.dropped      = o_drop;
  assign trk.last_result  = o_last;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, queue pop and cost memory ports
  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    cost_we    = 1'b0;
    cost_wdata = gated;
    cost_waddr = {i_cnt[DW-1:0], j_cnt[DW-1:0]};
    cost_raddr = '0;
    unique case (state)
      B_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd_flags.last) begin
            state_next = (n_cnt != '0 && m_new != '0) ? B_DIFF : B_SINIT;
          end
        end
      end
      B_DIFF: state_next = B_GATE;
      B_GATE: begin
        if (far) begin
          cost_we    = 1'b1;
          state_next = pair_last ? B_SINIT : B_DIFF;
        end else begin
          state_next = B_SQ;
        end
      end
      B_SQ: if (sq_idx == 2'd2) state_next = B_CMP;
      B_CMP: begin
        if (sq_over) begin
          cost_we    = 1'b1;
          state_next = pair_last ? B_SINIT : B_DIFF;
        end else begin
          state_next = B_SQRT;
        end
      end
      B_SQRT: begin
        if (bitv[0]) begin
          cost_we    = 1'b1;
          cost_wdata = COST_BITS'(root_step);
          state_next = pair_last ? B_SINIT : B_DIFF;
        end
      end
      B_SINIT: state_next = (k_new == '0) ? B_TADDR : B_ROW;
      B_ROW:   state_next = B_ITER;
      B_ITER:  state_next = B_ADDR;
      B_ADDR: begin
        cost_raddr = {i0m[DW-1:0], jm[DW-1:0]};
        if (!used[jx]) begin
          state_next = B_CALC;
        end else if (j_at_k) begin
          state_next = B_UPD;
        end
      end
      B_CALC: state_next = j_at_k ? B_UPD : B_ADDR;
      B_UPD:  if (j_at_k) state_next = B_CHK;
      B_CHK:  state_next = (p_arr[j0] != '0) ? B_ITER : B_AUG;
      B_AUG: begin
        if (way[j0] == '0) begin
          state_next = (i_cnt == k_cnt) ? B_RC : B_ROW;
        end
      end
      B_RC: if (j_at_k) state_next = B_TADDR;
      B_TADDR: begin
        cost_raddr = {ri, rc[ri]};
        state_next = (i_cnt == n_cnt) ? B_PACK : B_TCALC;
      end
      B_TCALC: state_next = (match_ok && alert_fire) ? B_PREP : B_TADDR;
      B_PACK:  if (i_cnt == n_cnt) state_next = B_SPAWN;
      B_SPAWN: if (j_cnt == m_cnt) state_next = B_PREP;
      B_PREP:  state_next = B_EMIT;
      B_EMIT:  if (load && emit_last) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // Cost memory, registered read
  always_ff @(posedge clk) begin
    if (cost_we) begin
      cost_mem[cost_waddr] <= cost_wdata;
    end
    cost_rd <= cost_mem[cost_raddr];
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      n_cnt     <= '0;
      m_cnt     <= '0;
      id_ctr    <= '0;
      drop_flag <= 1'b0;
      ovalid    <= 1'b0;
    end else begin
      // Retire the result once taken
      if (trk.valid && trk.ready) begin
        ovalid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (cmd_valid) begin
            if (cmd_flags.store) begin
              d_x[m_cnt[DIW-1:0]] <= cmd_x;
              d_y[m_cnt[DIW-1:0]] <= cmd_y;
              d_z[m_cnt[DIW-1:0]] <= cmd_z;
              m_cnt <= m_new;
            end
            if (cmd_flags.drop) begin
              drop_flag <= 1'b1;
            end
            if (cmd_flags.last) begin
              stamp <= cmd_stamp;
              i_cnt <= '0;
              j_cnt <= '0;
            end
          end
        end
        // Distance of one track/detection pair
        B_DIFF: begin
          dif[0] <= abs_diff(t_x[ti], d_x[j_cnt[DIW-1:0]]);
          dif[1] <= abs_diff(t_y[ti], d_y[j_cnt[DIW-1:0]]);
          dif[2] <= abs_diff(t_z[ti], d_z[j_cnt[DIW-1:0]]);
        end
        B_GATE: begin
          acc    <= '0;
          sq_idx <= '0;
        end
        B_SQ: begin
          acc    <= acc + SQ_BITS'(sq_prod);
          sq_idx <= sq_idx + 1'b1;
        end
        B_CMP: begin
          rem  <= acc;
          root <= '0;
          bitv <= SQ_BITS'(1) << SQRT_TOP;
        end
        B_SQRT: begin
          if (take) begin
            rem <= rem - trial;
          end
          root <= root_step;
          bitv <= bitv >> 2;
        end
        default: ;
      endcase

      // Advance the pair counters after a cost is written
      if (cost_we) begin
        if (j_cnt == m_cnt - 1'b1) begin
          j_cnt <= '0;
          i_cnt <= i_cnt + 1'b1;
        end else begin
          j_cnt <= j_cnt + 1'b1;
        end
      end

      unique case (state)
        // Clear potentials and matching
        B_SINIT: begin
          k_cnt <= k_new;
          for (int q = 0; q <= DIM; q++) begin
            u_pot[q] <= '0;
            v_pot[q] <= '0;
            p_arr[q] <= '0;
            way[q]   <= '0;
          end
          rc_ok     <= '0;
          matched   <= '0;
          alert_hit <= 1'b0;
          i_cnt     <= (k_new == '0) ? '0 : CW'(1);
        end
        B_ROW: begin
          p_arr[0] <= i_cnt[IW-1:0];
          j0 <= '0;
          for (int q = 0; q <= DIM; q++) begin
            minv[q] <= BIG_COST;
          end
          used <= '0;
        end
        B_ITER: begin
          i0 <= p_arr[j0];
          used[j0] <= 1'b1;
          delta <= BIG_COST;
          j1 <= '0;
          j_cnt <= CW'(1);
        end
        B_ADDR: begin
          if (used[jx]) begin
            j_cnt <= j_at_k ? '0 : j_cnt + 1'b1;
          end
        end
        B_CALC: begin
          minv[jx] <= nmin;
          if (cur < minv[jx]) begin
            way[jx] <= j0;
          end
          if (nmin < delta) begin
            delta <= nmin;
            j1 <= jx;
          end
          j_cnt <= j_at_k ? '0 : j_cnt + 1'b1;
        end
        // Shift potentials by delta
        B_UPD: begin
          if (used[jx]) begin
            u_pot[p_arr[jx]] <= u_pot[p_arr[jx]] + delta;
            v_pot[jx] <= v_pot[jx] - delta;
          end else begin
            minv[jx] <= minv[jx] - delta;
          end
          if (j_at_k) begin
            j0 <= j1;
          end else begin
            j_cnt <= j_cnt + 1'b1;
          end
        end
        // Walk the alternating path back
        B_AUG: begin
          p_arr[j0] <= p_arr[way[j0]];
          j0 <= way[j0];
          if (way[j0] == '0) begin
            i_cnt <= i_cnt + 1'b1;
            j_cnt <= CW'(1);
          end
        end
        B_RC: begin
          if (p_arr[jx] != '0) begin
            rc[DW'(p_arr[jx] - 1'b1)]    <= jm[DW-1:0];
            rc_ok[DW'(p_arr[jx] - 1'b1)] <= 1'b1;
          end
          if (j_at_k) begin
            i_cnt <= '0;
          end else begin
            j_cnt <= j_cnt + 1'b1;
          end
        end
        B_TADDR: begin
          if (i_cnt == n_cnt) begin
            i_cnt <= '0;
            w_cnt <= '0;
          end
        end
        // Update one track from its assignment
        B_TCALC: begin
          if (match_ok) begin
            t_x[ti] <= d_x[dj];
            t_y[ti] <= d_y[dj];
            t_z[ti] <= d_z[dj];
            t_seen[ti]  <= stamp;
            t_miss[ti]  <= '0;
            matched[dj] <= 1'b1;
            t_fset[ti]  <= 1'b1;
            t_first[ti] <= first_eff;
            if (alert_fire) begin
              t_alert[ti] <= 1'b1;
              alert_hit   <= 1'b1;
              alert_idx   <= ti;
            end
          end else begin
            t_miss[ti]  <= miss_new;
            t_fset[ti]  <= 1'b0;
            t_first[ti] <= '0;
            if ((stamp >= t_seen[ti] && stamp - t_seen[ti] >= cfg.lost_timeout_ms) ||
                miss_new > cfg.max_missed) begin
              t_valid[ti] <= 1'b0;
            end
          end
          i_cnt <= i_cnt + 1'b1;
        end
        // Compact valid tracks to the front
        B_PACK: begin
          if (i_cnt == n_cnt) begin
            n_cnt <= w_cnt;
            j_cnt <= '0;
          end else begin
            if (t_valid[ti]) begin
              t_x[w_cnt[TIW-1:0]]     <= t_x[ti];
              t_y[w_cnt[TIW-1:0]]     <= t_y[ti];
              t_z[w_cnt[TIW-1:0]]     <= t_z[ti];
              t_id[w_cnt[TIW-1:0]]    <= t_id[ti];
              t_seen[w_cnt[TIW-1:0]]  <= t_seen[ti];
              t_first[w_cnt[TIW-1:0]] <= t_first[ti];
              t_miss[w_cnt[TIW-1:0]]  <= t_miss[ti];
              t_fset[w_cnt[TIW-1:0]]  <= t_fset[ti];
              t_valid[w_cnt[TIW-1:0]] <= 1'b1;
              t_alert[w_cnt[TIW-1:0]] <= t_alert[ti];
              w_cnt <= w_cnt + 1'b1;
            end
            i_cnt <= i_cnt + 1'b1;
          end
        end
        // New tracks for unmatched detections
        B_SPAWN: begin
          if (j_cnt != m_cnt) begin
            if (!matched[j_cnt[DIW-1:0]]) begin
              if (n_cnt >= CW'(MAX_TRACKS)) begin
                drop_flag <= 1'b1;
              end else begin
                t_id[n_cnt[TIW-1:0]]    <= id_ctr;
                t_x[n_cnt[TIW-1:0]]     <= d_x[j_cnt[DIW-1:0]];
                t_y[n_cnt[TIW-1:0]]     <= d_y[j_cnt[DIW-1:0]];
                t_z[n_cnt[TIW-1:0]]     <= d_z[j_cnt[DIW-1:0]];
                t_seen[n_cnt[TIW-1:0]]  <= stamp;
                t_first[n_cnt[TIW-1:0]] <= stamp;
                t_fset[n_cnt[TIW-1:0]]  <= 1'b1;
                t_miss[n_cnt[TIW-1:0]]  <= '0;
                t_valid[n_cnt[TIW-1:0]] <= 1'b1;
                t_alert[n_cnt[TIW-1:0]] <= 1'b0;
                n_cnt  <= n_cnt + 1'b1;
                id_ctr <= id_ctr + 1'b1;
              end
            end
            j_cnt <= j_cnt + 1'b1;
          end
        end
        B_PREP: begin
          frame_drop <= drop_flag;
          drop_flag  <= 1'b0;
          m_cnt      <= '0;
          i_cnt      <= '0;
        end
        // Load one table entry into the output register
        B_EMIT: begin
          if (load) begin
            ovalid <= 1'b1;
            o_drop <= frame_drop;
            o_last <= emit_last;
            if (n_cnt == '0) begin
              o_id    <= '0;
              o_x     <= '0;
              o_y     <= '0;
              o_z     <= '0;
              o_miss  <= '0;
              o_alert <= 1'b0;
              o_valid <= 1'b0;
              o_empty <= 1'b1;
            end else begin
              o_id    <= t_id[ti];
              o_x     <= t_x[ti];
              o_y     <= t_y[ti];
              o_z     <= t_z[ti];
              o_miss  <= t_miss[ti];
              o_alert <= alert_hit && (alert_idx == ti);
              o_valid <= t_valid[ti];
              o_empty <= 1'b0;
            end
            i_cnt <= i_cnt + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

`default_nettype wire

/* design/multi_object_tracker_assignment_core.sv */
// Top level of the multi-object tracker association core: configuration
// registers, front end, command queue and back end. Depends on mot_pkg,
// mot_channels, mot_front, mot_fifo and mot_back.
//
//   port       dir  handshake        carries
//   det        in   valid/ready      one detection or frame marker
//   trk        out  valid/ready      one track table entry per result
//   wr_*       in   wr_en strobe     register index and data
//
// Items that do not end a frame pass the front into a four-entry queue; the
// front is not ready while the queue is full. A frame end runs the back: a cost
// per stored track/detection pair (shared multiplier and square root), a
// Hungarian solve over k = max(tracks, detections) on one cost memory read port,
// then an update per track, then one result per cycle while the receiver is
// ready. Reset is synchronous and clears the table; output stalls hold the back.
`default_nettype none

module multi_object_tracker_assignment_core import mot_pkg::*; #(
  parameter int MAX_TRACKS     = MAX_TRACKS_DEF,
  parameter int MAX_DETECTIONS = MAX_DETECTIONS_DEF,
  parameter int COORD_BITS     = COORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  mot_det_if.sink             det,
  mot_trk_if.source           trk,
  input  logic                wr_en,
  input  logic [1:0]          wr_index,
  input  logic [REG_BITS-1:0] wr_data
);
  localparam int CMD_BITS = FLAG_BITS + 3 * COORD_BITS + STAMP_BITS;

  mot_cfg_t cfg;
  logic push, pop, full, empty;
  logic [CMD_BITS-1:0] push_data, head;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_distance      <= DIST_BITS'(768);
      cfg.max_missed        <= MISS_BITS'(5);
      cfg.alert_duration_ms <= STAMP_BITS'(10000);
      cfg.lost_timeout_ms   <= STAMP_BITS'(10000);
    end else if (wr_en) begin
      unique case (wr_index)
        REG_MAX_DISTANCE:   cfg.max_distance      <= wr_data[DIST_BITS-1:0];
        REG_MAX_MISSED:     cfg.max_missed        <= wr_data[MISS_BITS-1:0];
        REG_ALERT_DURATION: cfg.alert_duration_ms <= wr_data;
        REG_LOST_TIMEOUT:   cfg.lost_timeout_ms   <= wr_data;
      endcase
    end
  end

  mot_front #(
    .MAX_DETECTIONS(MAX_DETECTIONS),
    .COORD_BITS    (COORD_BITS),
    .CMD_BITS      (CMD_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .det      (det),
    .push     (push),
    .push_data(push_data),
    .full     (full)
  );

  mot_fifo #(
    .WIDTH(CMD_BITS),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .head     (head),
    .full     (full),
    .empty    (empty)
  );

  mot_back #(
    .MAX_TRACKS    (MAX_TRACKS),
    .MAX_DETECTIONS(MAX_DETECTIONS),
    .COORD_BITS    (COORD_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd_valid(!empty),
    .cmd_pop  (pop),
    .cmd_flags(mot_flags_t'(head[CMD_BITS-1 -: FLAG_BITS])),
    .cmd_x    (head[STAMP_BITS + 3*COORD_BITS - 1 -: COORD_BITS]),
    .cmd_y    (head[STAMP_BITS + 2*COORD_BITS - 1 -: COORD_BITS]),
    .cmd_z    (head[STAMP_BITS + COORD_BITS - 1 -: COORD_BITS]),
    .cmd_stamp(head[STAMP_BITS-1:0]),
    .trk      (trk)
  );
endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for multi_object_tracker_assignment_core.
// Depends on mot_pkg and the mot_det_if / mot_trk_if channel interfaces.
// Feeds detection frames, predicts the emitted track table, checks each transfer.
`timescale 1ns / 100ps

module tb_top;
  import mot_pkg::*;

  localparam int NT = MAX_TRACKS_DEF;
  localparam int ND = MAX_DETECTIONS_DEF;
  localparam int CB = COORD_BITS_DEF;
  localparam int WATCH_LIMIT = 200000;
  localparam int HOLD_CYCLES = 600;

  typedef struct {
    logic signed [CB-1:0] x, y, z;
    logic [31:0] stamp;
    logic has_det, fend;
  } det_item_t;

  typedef struct {
    logic [15:0] id;
    logic signed [CB-1:0] x, y, z;
    logic [7:0] miss;
    logic alert, valid, empty, dropped, last;
  } trk_res_t;

  typedef struct {
    longint x, y, z;
    logic [15:0] id;
    logic [31:0] seen, first;
    bit first_set, valid, alerted;
    int miss;
  } trk_rec_t;

  logic clk, rst;
  logic wr_en;
  logic [1:0] wr_index;
  logic [REG_BITS-1:0] wr_data;

  mot_det_if det_if ();
  mot_trk_if trk_if ();

  multi_object_tracker_assignment_core dut (
    .clk(clk), .rst(rst), .det(det_if), .trk(trk_if),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  // Predictor state
  logic [15:0] cfg_dist;
  logic [7:0]  cfg_miss;
  logic [31:0] cfg_alert, cfg_lost;
  trk_rec_t    table_q[NT];
  int          n_tracks, n_dets;
  logic [15:0] next_id;
  longint      det_buf[ND][3];
  bit          drop_pend;
  longint      cost_m[16][16];
  int          col_of_row[16];

  det_item_t pending_items[$];
  trk_res_t  expected_tracks[$];
  det_item_t drv_item;

  int idle_mode;
  bit hold_go, hold_done;
  int hold_cnt;
  int n_errors, n_items, n_frames, n_results, n_alerts, n_drops, quiet;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint udiff(longint a, longint b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic longint gate_cost(int t, int d);
    longint dx, dy, dz, g, md;
    md = longint'(cfg_dist);
    g = md + GATE_MARGIN;
    dx = udiff(table_q[t].x, det_buf[d][0]);
    dy = udiff(table_q[t].y, det_buf[d][1]);
    dz = udiff(table_q[t].z, det_buf[d][2]);
    if (dx > md || dy > md || dz > md) return g;
    if (dx * dx + dy * dy + dz * dz > md * md) return g;
    return longint'(int_sqrt(dx * dx + dy * dy + dz * dz));
  endfunction

  // Minimum-cost assignment with row/column potentials
  function automatic void solve_assignment(int k);
    longint u[17], v[17], mv[17];
    int p[17], way[17];
    bit used[17];
    int i, j, j0, j1, i0;
    longint delta, cur;
    for (j = 0; j <= k; j++) begin
      u[j] = 0; v[j] = 0; p[j] = 0; way[j] = 0;
    end
    for (i = 1; i <= k; i++) begin
      j0 = 0;
      p[0] = i;
      for (j = 0; j <= k; j++) begin
        mv[j] = 64'h1 << 60; used[j] = 0;
      end
      do begin
        i0 = p[j0];
        j1 = 0;
        delta = 64'h1 << 60;
        used[j0] = 1;
        for (j = 1; j <= k; j++) begin
          if (!used[j]) begin
            cur = cost_m[i0-1][j-1] - u[i0] - v[j];
            if (cur < mv[j]) begin
              mv[j] = cur; way[j] = j0;
            end
            if (mv[j] < delta) begin
              delta = mv[j]; j1 = j;
            end
          end
        end
        for (j = 0; j <= k; j++) begin
          if (used[j]) begin
            u[p[j]] += delta; v[j] -= delta;
          end else begin
            mv[j] -= delta;
          end
        end
        j0 = j1;
      end while (p[j0] != 0);
      do begin
        j1 = way[j0];
        p[j0] = p[j1];
        j0 = j1;
      end while (j0 != 0);
    end
    for (j = 1; j <= k; j++)
      if (p[j] != 0) col_of_row[p[j]-1] = j - 1;
  endfunction

  // Run one frame and queue the emitted table
  function automatic void predict_frame(logic [31:0] stamp);
    int n, m, k, i, j, w, alert_at;
    bit matched[ND];
    logic [31:0] el;
    trk_res_t r;
    n = n_tracks;
    m = n_dets;
    k = (n > m) ? n : m;
    alert_at = -1;
    foreach (matched[j]) matched[j] = 0;
    for (i = 0; i < 16; i++) col_of_row[i] = -1;
    for (i = 0; i < k; i++)
      for (j = 0; j < k; j++)
        cost_m[i][j] = (i < n && j < m) ? gate_cost(i, j) : 0;
    if (k > 0) solve_assignment(k);
    for (i = 0; i < n; i++) begin
      j = col_of_row[i];
      if (j >= 0 && j < m && cost_m[i][j] <= longint'(cfg_dist)) begin
        table_q[i].x = det_buf[j][0];
        table_q[i].y = det_buf[j][1];
        table_q[i].z = det_buf[j][2];
        table_q[i].seen = stamp;
        table_q[i].miss = 0;
        matched[j] = 1;
        if (!table_q[i].first_set) begin
          table_q[i].first_set = 1; table_q[i].first = stamp;
        end
        el = stamp - table_q[i].first;
        if (stamp >= table_q[i].first && el >= cfg_alert && !table_q[i].alerted) begin
          table_q[i].alerted = 1;
          alert_at = i;
          break;
        end
      end else begin
        if (table_q[i].miss < 255) table_q[i].miss++;
        el = stamp - table_q[i].seen;
        if (stamp >= table_q[i].seen && el >= cfg_lost) table_q[i].valid = 0;
        table_q[i].first_set = 0;
        table_q[i].first = 0;
        if (table_q[i].miss > cfg_miss) table_q[i].valid = 0;
      end
    end
    if (alert_at < 0) begin
      w = 0;
      for (i = 0; i < n; i++)
        if (table_q[i].valid) table_q[w++] = table_q[i];
      n_tracks = w;
      for (j = 0; j < m; j++) begin
        if (matched[j]) continue;
        if (n_tracks >= NT) begin
          drop_pend = 1;
          continue;
        end
        table_q[n_tracks] = '{x: det_buf[j][0], y: det_buf[j][1], z: det_buf[j][2],
                              id: next_id, seen: stamp, first: stamp, first_set: 1,
                              valid: 1, alerted: 0, miss: 0};
        next_id++;
        n_tracks++;
      end
    end else begin
      n_alerts++;
    end
    n_dets = 0;
    if (drop_pend) n_drops++;
    if (n_tracks == 0) begin
      r = '{default: 0};
      r.empty = 1; r.dropped = drop_pend; r.last = 1;
      expected_tracks.push_back(r);
    end
    for (i = 0; i < n_tracks; i++) begin
      r.id = table_q[i].id;
      r.x = table_q[i].x[CB-1:0];
      r.y = table_q[i].y[CB-1:0];
      r.z = table_q[i].z[CB-1:0];
      r.miss = table_q[i].miss[7:0];
      r.alert = (i == alert_at);
      r.valid = table_q[i].valid;
      r.empty = 0;
      r.dropped = drop_pend;
      r.last = (i == n_tracks - 1);
      expected_tracks.push_back(r);
    end
    drop_pend = 0;
  endfunction

  function automatic void predict_item(det_item_t it);
    n_items++;
    if (it.has_det) begin
      if (n_dets < ND) begin
        det_buf[n_dets][0] = longint'(it.x);
        det_buf[n_dets][1] = longint'(it.y);
        det_buf[n_dets][2] = longint'(it.z);
        n_dets++;
      end else begin
        drop_pend = 1;
      end
    end
    if (it.fend) begin
      n_frames++;
      predict_frame(it.stamp);
    end
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    n_errors++;
    $display("MISMATCH %0t result %0d: %s got %0h want %0h", $time, n_results, field, got, want);
  endtask

  // Clock and reset
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1;
    wr_en = 0; wr_index = REG_MAX_DISTANCE; wr_data = '0;
    det_if.valid = 0; det_if.pos_x = '0; det_if.pos_y = '0; det_if.pos_z = '0;
    det_if.stamp_ms = '0; det_if.has_detection = 0; det_if.frame_end = 0;
    trk_if.ready = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
  end

  // Driver: offer queued items, predict on each transfer
  always @(posedge clk) begin
    if (rst) begin
      det_if.valid <= 0;
    end else if (!det_if.valid || det_if.ready) begin
      if (det_if.valid) predict_item(drv_item);
      if (pending_items.size() > 0 &&
          !(idle_mode == 0 && $urandom_range(99) < 19) &&
          !(idle_mode == 1 && $urandom_range(99) < 64)) begin
        drv_item = pending_items.pop_front();
        det_if.valid <= 1;
        det_if.pos_x <= drv_item.x;
        det_if.pos_y <= drv_item.y;
        det_if.pos_z <= drv_item.z;
        det_if.stamp_ms <= drv_item.stamp;
        det_if.has_detection <= drv_item.has_det;
        det_if.frame_end <= drv_item.fend;
      end else begin
        det_if.valid <= 0;
      end
    end
  end

  // Monitor: compare each result transfer, drive ready with stalls
  always @(posedge clk) begin
    trk_res_t e;
    if (rst) begin
      trk_if.ready <= 0;
      hold_cnt <= 0;
      hold_done <= 0;
    end else begin
      if (trk_if.valid && trk_if.ready) begin
        if (expected_tracks.size() == 0) begin
          report_mismatch("unexpected result", trk_if.track_id, 0);
        end else begin
          e = expected_tracks.pop_front();
          if (trk_if.track_id !== e.id) report_mismatch("track_id", trk_if.track_id, e.id);
          if (trk_if.track_x !== e.x) report_mismatch("track_x", trk_if.track_x, e.x);
          if (trk_if.track_y !== e.y) report_mismatch("track_y", trk_if.track_y, e.y);
          if (trk_if.track_z !== e.z) report_mismatch("track_z", trk_if.track_z, e.z);
          if (trk_if.missed_count !== e.miss)
            report_mismatch("missed_count", trk_if.missed_count, e.miss);
          if (trk_if.alert_now !== e.alert) report_mismatch("alert_now", trk_if.alert_now, e.alert);
          if (trk_if.still_valid !== e.valid)
            report_mismatch("still_valid", trk_if.still_valid, e.valid);
          if (trk_if.table_empty !== e.empty)
            report_mismatch("table_empty", trk_if.table_empty, e.empty);
          if (trk_if.dropped !== e.dropped) report_mismatch("dropped", trk_if.dropped, e.dropped);
          if (trk_if.last_result !== e.last)
            report_mismatch("last_result", trk_if.last_result, e.last);
        end
        n_results++;
      end
      // long hold-off, requested once by the stimulus
      if (hold_go && !hold_done) begin
        hold_done <= 1;
        hold_cnt <= HOLD_CYCLES;
        trk_if.ready <= 0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        trk_if.ready <= 0;
      end else begin
        trk_if.ready <= !((idle_mode == 0 && $urandom_range(99) < 64) ||
                          (idle_mode == 1 && $urandom_range(99) < 19));
      end
    end
  end

  // Watchdog: end the run after a long stretch with no transfer
  always @(posedge clk) begin
    if (rst || (det_if.valid && det_if.ready) || (trk_if.valid && trk_if.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WATCH_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", expected_tracks.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Stimulus helpers
  longint scene[$][3];
  logic [31:0] frame_stamp;

  function automatic logic signed [CB-1:0] clamp_coord(longint v);
    if (v > 524287) return 20'sh7FFFF;
    if (v < -524288) return 20'sh80000;
    return v[CB-1:0];
  endfunction

  task automatic push_item(longint x, longint y, longint z, logic hd, logic fe);
    det_item_t it;
    it.x = clamp_coord(x);
    it.y = clamp_coord(y);
    it.z = clamp_coord(z);
    it.stamp = fe ? frame_stamp : $urandom;
    it.has_det = hd;
    it.fend = fe;
    pending_items.push_back(it);
  endtask

  task automatic random_frame(output int count);
    int i, nd, last_sep;
    longint p[3];
    count = 0;
    if ($urandom_range(99) < 8) frame_stamp = frame_stamp - $urandom_range(3000);
    else if ($urandom_range(99) < 5) frame_stamp = $urandom;
    else frame_stamp = frame_stamp + $urandom_range(200, 2500);
    if ($urandom_range(99) < 10) begin
      push_item(0, 0, 0, 0, 1);
      count = 1;
      return;
    end
    // move the scene, then occasionally lose or add an object
    foreach (scene[i]) for (int a = 0; a < 3; a++)
      scene[i][a] = clamp_coord(scene[i][a] + $urandom_range(400) - 200);
    if (scene.size() > 0 && $urandom_range(99) < 20)
      scene.delete($urandom_range(scene.size() - 1));
    if (scene.size() < 18 && $urandom_range(99) < 35) begin
      p[0] = $urandom_range(800000) - 400000;
      p[1] = $urandom_range(800000) - 400000;
      p[2] = $urandom_range(800000) - 400000;
      scene.push_back(p);
    end
    nd = scene.size();
    last_sep = (nd == 0) || ($urandom_range(1) == 0);
    for (i = 0; i < nd; i++) begin
      if ($urandom_range(99) < 10) begin
        push_item($urandom_range(1000), 0, 0, 0, 0);
        count++;
      end
      if ($urandom_range(99) < 8)
        push_item($urandom_range(1048575) - 524288, $urandom_range(1048575) - 524288,
                  $urandom_range(1048575) - 524288, 1, 0);
      else
        push_item(scene[i][0], scene[i][1], scene[i][2], 1, !last_sep && i == nd - 1);
      count++;
    end
    if (last_sep) begin
      push_item(0, 0, 0, 0, 1);
      count++;
    end
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || det_if.valid || expected_tracks.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    wr_en <= 1;
    wr_index <= idx;
    wr_data <= val;
    case (idx)
      REG_MAX_DISTANCE: cfg_dist = val[15:0];
      REG_MAX_MISSED:   cfg_miss = val[7:0];
      REG_ALERT_DURATION: cfg_alert = val;
      default: cfg_lost = val;
    endcase
  endtask

  task automatic set_config(logic [31:0] d, logic [31:0] mm, logic [31:0] al, logic [31:0] lo);
    write_reg(REG_MAX_DISTANCE, d);
    write_reg(REG_MAX_MISSED, mm);
    write_reg(REG_ALERT_DURATION, al);
    write_reg(REG_LOST_TIMEOUT, lo);
    @(posedge clk);
    wr_en <= 0;
  endtask

  task automatic random_phase(int quota);
    int got, c;
    got = 0;
    while (got < quota) begin
      random_frame(c);
      got += c;
    end
    wait_idle();
  endtask

  initial begin
    cfg_dist = 768; cfg_miss = 5; cfg_alert = 10000; cfg_lost = 10000;
    n_tracks = 0; n_dets = 0; next_id = 0; drop_pend = 0;
    n_errors = 0; n_items = 0; n_frames = 0; n_results = 0; n_alerts = 0; n_drops = 0;
    quiet = 0; idle_mode = 0; hold_go = 0;
    @(negedge rst);
    @(posedge clk);

    // Directed: coordinate extremes, empty frame, stamp extremes, buffer overflow
    frame_stamp = 0;
    push_item(524287, 524287, 524287, 1, 0);
    push_item(-524288, -524288, -524288, 1, 0);
    push_item(0, 0, 0, 1, 1);
    frame_stamp = 32'hFFFF_FFFF;
    push_item(0, 0, 0, 0, 1);
    frame_stamp = 32'h0000_1000;
    for (int i = 0; i < 17; i++)
      push_item(i * 30000 - 250000, 1000 - i * 5000, i * 7, 1, i == 16);
    frame_stamp = 32'h0000_0800;
    push_item(0, 0, 0, 0, 1);
    wait_idle();

    // Defaults, sender lightly idle and receiver heavily idle
    frame_stamp = 0;
    random_phase(40);

    // Widest gate, no tolerance, immediate alerts and losses
    set_config(32'hFFFF, 0, 0, 0);
    idle_mode = 1;
    random_phase(35);

    // Zero gate, largest limits; receiver holds off for a long stretch
    set_config(0, 255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    idle_mode = 2;
    hold_go = 1;
    random_phase(35);

    // Moderate settings that let tracks persist long enough to alert
    set_config(2000, 3, 6000, 20000);
    random_phase(40);

    $display("covered %0d items in %0d frames, %0d track results checked",
             n_items, n_frames, n_results);
    $display("frames with an alert stop: %0d, frames with dropped detections: %0d",
             n_alerts, n_drops);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
design/mot_pkg.sv
design/mot_channels.sv
design/mot_fifo.sv
design/mot_front.sv
design/mot_back.sv
design/multi_object_tracker_assignment_core.sv
tb/tb_top.sv
